[hdl/stm_pkg.sv]
package stm_pkg;

    localparam int POS_W     = 16;
    localparam int TGT_W     = 16;
    localparam int MIN_W     = 16;
    localparam int SPAN_W    = 24;
    localparam int ELAPSED_W = 25;
    localparam int CMP_W     = ((POS_W > TGT_W) ? POS_W : TGT_W) + 1;
    localparam int DIV_W     = CMP_W + 1;
    localparam int DCNT_W    = $clog2(SPAN_W);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = MIN_W'(1000);
    localparam logic [SPAN_W-1:0] MAX_SPAN_RST     = SPAN_W'(10000);

    typedef enum logic {
        REG_MIN_INTERVAL = 1'b0,
        REG_MAX_SPAN     = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ZERO = 1'b1
    } t_op;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_REV = 1'b1
    } t_dir;

    typedef struct packed {
        logic [MIN_W-1:0]  min_interval;
        logic [SPAN_W-1:0] max_span;
    } t_cfg;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b1001;
            2'd2:    pat = 4'b0101;
            2'd3:    pat = 4'b0110;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

[hdl/stm_regs.sv]
module stm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stm_pkg::ADDR_W-1:0]   paddr,
    input  logic [stm_pkg::DATA_W-1:0]   pwdata,
    output logic [stm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output stm_pkg::t_cfg                o_cfg
);

    stm_pkg::t_cfg    r_cfg;
    stm_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = stm_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval <= stm_pkg::MIN_INTERVAL_RST;
            r_cfg.max_span     <= stm_pkg::MAX_SPAN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                stm_pkg::REG_MIN_INTERVAL: r_cfg.min_interval <= pwdata[stm_pkg::MIN_W-1:0];
                stm_pkg::REG_MAX_SPAN:     r_cfg.max_span     <= pwdata[stm_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            stm_pkg::REG_MIN_INTERVAL: prdata = stm_pkg::DATA_W'(r_cfg.min_interval);
            stm_pkg::REG_MAX_SPAN:     prdata = stm_pkg::DATA_W'(r_cfg.max_span);
            default:                   prdata = '0;
        endcase
    end

endmodule

[hdl/stm_div.sv]
module stm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [stm_pkg::SPAN_W-1:0]   i_dividend,
    input  logic [stm_pkg::DIV_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [stm_pkg::SPAN_W-1:0]   o_quotient
);

    logic [stm_pkg::DIV_W-1:0]  r_rem;
    logic [stm_pkg::SPAN_W-1:0] r_quo;
    logic [stm_pkg::DIV_W-1:0]  r_dsr;
    logic [stm_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [stm_pkg::DIV_W:0]    shifted;
    logic [stm_pkg::DIV_W:0]    trial;
    logic                       fits;

    // restoring shift-subtract, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[stm_pkg::SPAN_W-1]};
    assign trial   = shifted - {1'b0, r_dsr};
    assign fits    = ~trial[stm_pkg::DIV_W];

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? trial[stm_pkg::DIV_W-1:0] : shifted[stm_pkg::DIV_W-1:0];
                r_quo <= {r_quo[stm_pkg::SPAN_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == stm_pkg::DCNT_W'(stm_pkg::SPAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/stepper_move_to_position.sv]
// channel | direction | handshake                  | word
// --------+-----------+----------------------------+-------------------------------
// in      | in        | i_in_valid / o_in_stall    | i_operation, i_target, i_hold
// out     | out       | o_out_valid / i_out_stall  | o_coils, o_position,
//         |           |                            | o_stepped, o_at_target
// cfg     | in        | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// A moving tick goes through ST_CALC, ST_DIV and ST_EVAL to ST_OUT, with ST_DIV
// waiting on the 24-step shift-subtract divider that forms max_span / (distance + 1);
// zeroing and at-target words go from ST_CALC straight to ST_OUT.
// The input is stalled from acceptance until the result is loaded into the
// output register; a waiting result lets the next word in, which then waits in ST_OUT.
// Synchronous active-low reset clears position, phase, counters, r_latch; not r_coils.
module stepper_move_to_position (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic signed [stm_pkg::TGT_W-1:0] i_target,
    input  logic                         i_hold,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [3:0]                   o_coils,
    output logic signed [stm_pkg::TGT_W-1:0] o_position,
    output logic                         o_stepped,
    output logic                         o_at_target,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stm_pkg::ADDR_W-1:0]   paddr,
    input  logic [stm_pkg::DATA_W-1:0]   pwdata,
    output logic [stm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EVAL,
        ST_OUT
    } t_state;

    stm_pkg::t_cfg cfg;

    t_state                           r_state, n_state;
    stm_pkg::t_op                     r_op;
    logic signed [stm_pkg::TGT_W-1:0] r_tgt;
    logic                             r_hold;
    logic [stm_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [1:0]                       r_phase, n_phase;
    logic [stm_pkg::ELAPSED_W-1:0]    r_elapsed, n_elapsed;
    stm_pkg::t_dir                    r_dir_last, n_dir_last;
    logic [3:0]                       r_latch, n_latch;
    logic                             r_stepped, n_stepped;
    logic [stm_pkg::DIV_W-1:0]        r_divisor, n_divisor;
    logic                             r_div_arm, n_div_arm;

    logic                             r_out_valid, n_out_valid;
    logic [3:0]                       r_coils, n_coils;
    logic [stm_pkg::TGT_W-1:0]        r_position, n_position;
    logic                             r_out_stepped, n_out_stepped;
    logic                             r_at, n_at;

    logic signed [stm_pkg::CMP_W-1:0] pos_s;
    logic signed [stm_pkg::CMP_W-1:0] tgt_s;
    logic [stm_pkg::CMP_W-1:0]        pos_z;
    logic [stm_pkg::CMP_W-1:0]        distance;
    stm_pkg::t_dir                    dir;
    logic                             at_now;
    logic                             div_start;
    logic                             div_done;
    logic [stm_pkg::SPAN_W-1:0]       quotient;
    logic [stm_pkg::ELAPSED_W-1:0]    interval;
    logic                             out_free;

    stm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cfg.max_span),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign pos_s    = stm_pkg::CMP_W'($signed(r_pos));
    assign tgt_s    = stm_pkg::CMP_W'(r_tgt);
    assign pos_z    = stm_pkg::CMP_W'(r_pos);
    assign at_now   = (pos_s == tgt_s);
    assign dir      = (tgt_s > pos_s) ? stm_pkg::DIR_FWD : stm_pkg::DIR_REV;
    assign distance = (dir == stm_pkg::DIR_FWD) ? (tgt_s - pos_s) : (pos_s - tgt_s);
    assign interval = stm_pkg::ELAPSED_W'(cfg.min_interval) + stm_pkg::ELAPSED_W'(quotient);
    assign out_free = ~r_out_valid | ~i_out_stall;

    assign div_start = r_div_arm;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_coils     = r_coils;
    assign o_position  = r_position;
    assign o_stepped   = r_out_stepped;
    assign o_at_target = r_at;

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_phase       = r_phase;
        n_elapsed     = r_elapsed;
        n_dir_last    = r_dir_last;
        n_latch       = r_latch;
        n_stepped     = r_stepped;
        n_divisor     = r_divisor;
        n_div_arm     = 1'b0;
        n_out_valid   = r_out_valid & i_out_stall;
        n_coils       = r_coils;
        n_position    = r_position;
        n_out_stepped = r_out_stepped;
        n_at          = r_at;
        case (r_state)
            ST_IDLE: begin
                n_stepped = 1'b0;
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_op == stm_pkg::OP_ZERO) begin
                    n_pos     = '0;
                    n_elapsed = '0;
                    n_state   = ST_OUT;
                end else if (at_now) begin
                    n_elapsed = '0;
                    n_state   = ST_OUT;
                end else begin
                    n_dir_last = dir;
                    n_elapsed  = ((dir != r_dir_last) ? '0 : r_elapsed) + 1'b1;
                    n_divisor  = {1'b0, distance} + 1'b1;
                    n_div_arm  = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_elapsed >= interval) begin
                    n_elapsed = '0;
                    n_stepped = 1'b1;
                    if (r_dir_last == stm_pkg::DIR_FWD) begin
                        n_phase = r_phase + 2'd1;
                        n_pos   = r_pos + 1'b1;
                        n_latch = stm_pkg::coil_pattern(r_phase + 2'd1);
                    end else begin
                        n_phase = r_phase - 2'd1;
                        n_pos   = r_pos - 1'b1;
                        n_latch = stm_pkg::coil_pattern(r_phase - 2'd1);
                    end
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_coils       = (at_now && !r_hold) ? 4'b0000 : r_latch;
                    n_position    = pos_z[stm_pkg::TGT_W-1:0];
                    n_out_stepped = r_stepped;
                    n_at          = at_now;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_phase       <= '0;
            r_elapsed     <= '0;
            r_dir_last    <= stm_pkg::DIR_FWD;
            r_latch       <= '0;
            r_stepped     <= 1'b0;
            r_div_arm     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pos         <= n_pos;
            r_phase       <= n_phase;
            r_elapsed     <= n_elapsed;
            r_dir_last    <= n_dir_last;
            r_latch       <= n_latch;
            r_stepped     <= n_stepped;
            r_div_arm     <= n_div_arm;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_op   <= stm_pkg::t_op'(i_operation);
            r_tgt  <= i_target;
            r_hold <= i_hold;
        end
        r_divisor     <= n_divisor;
        r_coils       <= n_coils;
        r_position    <= n_position;
        r_out_stepped <= n_out_stepped;
        r_at          <= n_at;
    end

endmodule
